FILE: rtl/core/ocg_pkg.sv
// shared types and constants of the overlap cost graph engine
// depends on nothing; imported by every module of the block but ocg_ram
package ocg_pkg;

  // default sizes
  localparam int OCG_MAX_VERTICES = 64;
  localparam int OCG_MAX_SYMBOLS  = 16;
  localparam int OCG_SYMBOL_BITS  = 4;

  // fixed field widths
  localparam int VIDX_W     = 6;
  localparam int WORD_IN_W  = 64;
  localparam int LEN_W      = 5;
  localparam int CNT_W      = 7;
  localparam int COST_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // item operations
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b1;

  // register reset values and limits
  localparam logic [LEN_W-1:0] WORD_LENGTH_RST  = 5'd10;
  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 7'd64;
  localparam logic [LEN_W-1:0] MIN_LEN          = 5'd2;

  // controller to datapath
  typedef struct packed {
    logic              wr_en;
    logic [VIDX_W-1:0] addr;
    logic              load_pre;
    logic              pre_zero;
    logic [LEN_W-1:0]  len;
    logic              col_vld;
    logic [VIDX_W-1:0] col;
    logic              last;
    logic              fixed_zero;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pend;
  } stat_t;

endpackage

FILE: rtl/core/overlap_cost_graph_engine.sv
// top level of the overlap cost graph engine
// depends on ocg_pkg, ocg_ctrl, ocg_dpath (and ocg_ram below it)
//
// channel  | handshake       | payload
// ---------+-----------------+-------------------------------------------------
// input    | start / busy    | in_op, in_vertex_index, in_word_symbols
// result   | out_valid       | out_column, out_edge_cost, out_is_edge, out_last
// config   | cfg_we          | cfg_index, cfg_data
//
// a load item leaves busy low, so loads may follow every cycle while no query runs
// a query reads the prefix word, loads it, then walks the columns,
// with one store read per column through a registered-read ram
// each column result passes the s1 register and the output register; results strobe one per cycle
// rst_n is synchronous; it clears the sequencer, the strobes and the registers
// word_length and vertex_count to 10 and 64; the word store is not cleared
// the receiver cannot stall: each result shows for exactly one cycle
module overlap_cost_graph_engine import ocg_pkg::*; #(
  parameter int MAX_VERTICES = OCG_MAX_VERTICES,
  parameter int MAX_SYMBOLS  = OCG_MAX_SYMBOLS,
  parameter int SYMBOL_BITS  = OCG_SYMBOL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic [VIDX_W-1:0]     in_vertex_index,
  input  logic [WORD_IN_W-1:0]  in_word_symbols,
  // result channel
  output logic                  out_valid,
  output logic [VIDX_W-1:0]     out_column,
  output logic [COST_W-1:0]     out_edge_cost,
  output logic                  out_is_edge,
  output logic                  out_last,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // command bundle from the sequencer, pipeline status back
  cmd_t  cmd;
  stat_t stat;

  // sequencer: holds the size registers, walks prefix read then every column
  ocg_ctrl #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_vertex_index(in_vertex_index),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .stat           (stat),
    .cmd            (cmd)
  );

  // datapath: word store, aligned prefix register, overlap compare, cost
  ocg_dpath #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_word_symbols(in_word_symbols),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_column     (out_column),
    .out_edge_cost  (out_edge_cost),
    .out_is_edge    (out_is_edge),
    .out_last       (out_last)
  );

endmodule

FILE: rtl/core/ocg_ram.sv
// generic simple dual port ram with registered read
// no dependencies
module ocg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/ocg_ctrl.sv
// controller: configuration registers and query sequencer
// depends on ocg_pkg
module ocg_ctrl import ocg_pkg::*; #(
  parameter int MAX_VERTICES = OCG_MAX_VERTICES,
  parameter int MAX_SYMBOLS  = OCG_MAX_SYMBOLS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic [VIDX_W-1:0]     in_vertex_index,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  stat_t                 stat,
  output cmd_t                  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PRE   = 2'd1;
  localparam logic [1:0] S_LOADP = 2'd2;
  localparam logic [1:0] S_RUN   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [LEN_W-1:0]  wl_r, wl_nxt;
  logic [CNT_W-1:0]  vc_r, vc_nxt;
  logic [VIDX_W-1:0] row_r, row_nxt;
  logic [VIDX_W-1:0] col_r, col_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              accept;
  logic              col_last;
  logic [LEN_W-1:0]  len_sat;
  logic [CNT_W-1:0]  count_sat;

  assign busy     = (state_r != S_IDLE) || stat.pend;
  assign accept   = start && !busy;
  assign col_last = (CNT_W'(col_r) + CNT_W'(1)) == count_r;

  // clamp the configured sizes into the supported range
  always_comb begin
    if (wl_r > LEN_W'(MAX_SYMBOLS)) begin
      len_sat = LEN_W'(MAX_SYMBOLS);
    end else if (wl_r < MIN_LEN) begin
      len_sat = MIN_LEN;
    end else begin
      len_sat = wl_r;
    end
    if (vc_r > CNT_W'(MAX_VERTICES)) begin
      count_sat = CNT_W'(MAX_VERTICES);
    end else begin
      count_sat = vc_r;
    end
  end

  always_comb begin
    wl_nxt    = wl_r;
    vc_nxt    = vc_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WORD_LENGTH:  wl_nxt = cfg_data[LEN_W-1:0];
        CFG_VERTEX_COUNT: vc_nxt = cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    len_nxt        = len_r;
    count_nxt      = count_r;
    cmd            = '0;
    cmd.len        = len_r;
    cmd.addr       = row_r;
    case (state_r)
      S_IDLE: begin
        cmd.addr = in_vertex_index;
        if (accept) begin
          if (in_op == OP_QUERY) begin
            row_nxt   = in_vertex_index;
            len_nxt   = len_sat;
            count_nxt = count_sat;
            col_nxt   = '0;
            state_nxt = S_PRE;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      S_PRE: begin
        // prefix word read issued here
        state_nxt = (count_r == '0) ? S_IDLE : S_LOADP;
      end
      S_LOADP: begin
        cmd.load_pre = 1'b1;
        cmd.pre_zero = CNT_W'(row_r) >= CNT_W'(MAX_VERTICES);
        state_nxt    = S_RUN;
      end
      S_RUN: begin
        cmd.addr       = col_r;
        cmd.col_vld    = 1'b1;
        cmd.col        = col_r;
        cmd.last       = col_last;
        cmd.fixed_zero = (col_r < VIDX_W'(2)) || (col_r == row_r);
        if (col_last) begin
          state_nxt = S_IDLE;
        end else begin
          col_nxt = col_r + VIDX_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wl_r    <= WORD_LENGTH_RST;
      vc_r    <= VERTEX_COUNT_RST;
    end else begin
      state_r <= state_nxt;
      wl_r    <= wl_nxt;
      vc_r    <= vc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    len_r   <= len_nxt;
    count_r <= count_nxt;
  end

`ifndef SYNTH
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_QUERY) |=> (state_r == S_PRE))
    else $error("query accepted but sequencer did not start");

  a_col_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && !col_last) |=> (col_r == VIDX_W'($past(col_r) + VIDX_W'(1))))
    else $error("column counter skipped");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (len_r >= MIN_LEN && len_r <= LEN_W'(MAX_SYMBOLS)))
    else $error("word length out of range during query");
`endif

endmodule

FILE: rtl/core/ocg_dpath.sv
// datapath: word store, prefix alignment, overlap search and cost
// depends on ocg_pkg and ocg_ram
module ocg_dpath import ocg_pkg::*; #(
  parameter int MAX_VERTICES = OCG_MAX_VERTICES,
  parameter int MAX_SYMBOLS  = OCG_MAX_SYMBOLS,
  parameter int SYMBOL_BITS  = OCG_SYMBOL_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  logic [WORD_IN_W-1:0] in_word_symbols,
  output stat_t                stat,
  output logic                 out_valid,
  output logic [VIDX_W-1:0]    out_column,
  output logic [COST_W-1:0]    out_edge_cost,
  output logic                 out_is_edge,
  output logic                 out_last
);

  localparam int WORD_W = MAX_SYMBOLS * SYMBOL_BITS;
  localparam int AW     = $clog2(MAX_VERTICES);
  localparam int SHW    = $clog2(WORD_W) + 1;

  logic [WORD_W-1:0] ram_rdata;
  logic              ram_we;
  logic [WORD_W-1:0] pre_top_r, pre_top_nxt;
  logic [LEN_W-1:0]  sh_sym;
  logic [SHW-1:0]    sh_bits;
  logic              s1_vld_r;
  logic [VIDX_W-1:0] s1_col_r;
  logic              s1_last_r;
  logic              s1_fz_r;
  logic [LEN_W-1:0]  best_ov;
  logic [LEN_W-1:0]  slack;
  logic [COST_W-1:0] cost;
  logic              out_valid_r;
  logic [VIDX_W-1:0] out_column_r;
  logic [COST_W-1:0] out_edge_cost_r;
  logic              out_last_r;

  assign ram_we = cmd.wr_en && (CNT_W'(cmd.addr) < CNT_W'(MAX_VERTICES));

  ocg_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_VERTICES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cmd.addr[AW-1:0]),
    .wdata(in_word_symbols[WORD_W-1:0]),
    .raddr(cmd.addr[AW-1:0]),
    .rdata(ram_rdata)
  );

  // align the prefix word so that its last symbol sits in the top slot
  assign sh_sym  = LEN_W'(MAX_SYMBOLS) - cmd.len;
  assign sh_bits = SHW'(sh_sym) * SHW'(SYMBOL_BITS);
  assign pre_top_nxt = cmd.pre_zero ? '0 : (ram_rdata << sh_bits);

  // every overlap candidate is compared at once, the longest one wins
  always_comb begin
    logic hit;
    best_ov = '0;
    for (int ov = 1; ov < MAX_SYMBOLS; ov++) begin
      hit = 1'b1;
      for (int j = 0; j < ov; j++) begin
        if (pre_top_r[(MAX_SYMBOLS - ov + j) * SYMBOL_BITS +: SYMBOL_BITS] !=
            ram_rdata[j * SYMBOL_BITS +: SYMBOL_BITS]) begin
          hit = 1'b0;
        end
      end
      if (hit && (LEN_W'(ov) < cmd.len)) begin
        best_ov = LEN_W'(ov);
      end
    end
  end

  // cost = (len-2-ov)/2+1 truncating toward zero, with slack = len-1-ov
  assign slack = cmd.len - LEN_W'(1) - best_ov;

  always_comb begin
    if (s1_fz_r || best_ov == '0) begin
      cost = '0;
    end else if (slack == '0) begin
      cost = COST_W'(1);
    end else begin
      cost = COST_W'((slack + LEN_W'(1)) >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= cmd.col_vld;
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pre) begin
      pre_top_r <= pre_top_nxt;
    end
    s1_col_r        <= cmd.col;
    s1_last_r       <= cmd.last;
    s1_fz_r         <= cmd.fixed_zero;
    out_column_r    <= s1_col_r;
    out_edge_cost_r <= cost;
    out_last_r      <= s1_last_r;
  end

  assign stat.pend     = s1_vld_r;
  assign out_valid     = out_valid_r;
  assign out_column    = out_column_r;
  assign out_edge_cost = out_edge_cost_r;
  assign out_is_edge   = out_edge_cost_r != '0;
  assign out_last      = out_last_r;

`ifndef SYNTH
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("item emitted right after last entry of a row");

  a_fixed_cols: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_column_r < VIDX_W'(2)) |-> (out_edge_cost_r == '0))
    else $error("nonzero cost on a fixed zero column");

  a_pre_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_pre |-> (!s1_vld_r && !cmd.col_vld))
    else $error("prefix word loaded while columns in flight");
`endif

endmodule

FILE: verif/ocg_sb_pkg.sv
`timescale 1ns / 100ps
// scoreboard for the overlap cost graph engine: word store copy, row predictor, result check
// depends on ocg_pkg for field widths, operation codes and register indexes
package ocg_sb_pkg;
  import ocg_pkg::*;

  typedef struct packed {
    logic [VIDX_W-1:0] column;
    logic [COST_W-1:0] edge_cost;
    logic              is_edge;
    logic              last;
  } row_entry_t;

  localparam int MAX_PRINTED = 40;

  class cost_row_scoreboard;
    logic [WORD_IN_W-1:0] words [OCG_MAX_VERTICES];
    logic [LEN_W-1:0]     len_reg;
    logic [CNT_W-1:0]     cnt_reg;
    row_entry_t           pending_entries [$];
    int                   errors;
    int                   checked;
    int                   loads;
    int                   queries;

    function new();
      for (int i = 0; i < OCG_MAX_VERTICES; i++) words[i] = '0;
      len_reg = WORD_LENGTH_RST;
      cnt_reg = VERTEX_COUNT_RST;
      errors  = 0;
      checked = 0;
      loads   = 0;
      queries = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_WORD_LENGTH) len_reg = data[LEN_W-1:0];
      else cnt_reg = data[CNT_W-1:0];
    endfunction

    function int eff_len();
      if (len_reg > OCG_MAX_SYMBOLS) return OCG_MAX_SYMBOLS;
      if (len_reg < MIN_LEN) return int'(MIN_LEN);
      return int'(len_reg);
    endfunction

    function int eff_count();
      return (cnt_reg > OCG_MAX_VERTICES) ? OCG_MAX_VERTICES : int'(cnt_reg);
    endfunction

    function int pending();
      return pending_entries.size();
    endfunction

    // longest proper suffix of pre that is a prefix of col
    function int overlap_len(logic [WORD_IN_W-1:0] pre, logic [WORD_IN_W-1:0] col, int len);
      bit same;
      for (int ov = len - 1; ov > 0; ov--) begin
        same = 1'b1;
        for (int j = 0; j < ov; j++)
          if (pre[(len - ov + j) * OCG_SYMBOL_BITS +: OCG_SYMBOL_BITS] !=
              col[j * OCG_SYMBOL_BITS +: OCG_SYMBOL_BITS]) same = 1'b0;
        if (same) return ov;
      end
      return 0;
    endfunction

    function void note_item(logic op, logic [VIDX_W-1:0] idx, logic [WORD_IN_W-1:0] word);
      row_entry_t e;
      int len, n, ov, cost;
      if (op == OP_LOAD) begin
        words[idx] = word;
        loads++;
        return;
      end
      queries++;
      len = eff_len();
      n   = eff_count();
      for (int c = 0; c < n; c++) begin
        cost = 0;
        // columns 0 and 1 and the diagonal never carry an edge
        if (c >= 2 && c != idx) begin
          ov = overlap_len(words[idx], words[c], len);
          if (ov != 0) cost = (len - 2 - ov) / 2 + 1;
        end
        e.column    = VIDX_W'(c);
        e.edge_cost = COST_W'(cost);
        e.is_edge   = (cost != 0);
        e.last      = (c == n - 1);
        pending_entries = {pending_entries, e};
      end
    endfunction

    task report(string what, int got, int want);
      if (errors < MAX_PRINTED)
        $display("mismatch: %s got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(logic [VIDX_W-1:0] col, logic [COST_W-1:0] cost, logic edge_bit,
                      logic last_bit);
      row_entry_t want;
      if (pending_entries.size() == 0) begin
        report("unexpected entry, column", int'(col), -1);
        return;
      end
      want = pending_entries.pop_front();
      checked++;
      if (col !== want.column) report("column", int'(col), int'(want.column));
      if (cost !== want.edge_cost) report("edge_cost", int'(cost), int'(want.edge_cost));
      if (edge_bit !== want.is_edge) report("is_edge", int'(edge_bit), int'(want.is_edge));
      if (last_bit !== want.last) report("last", int'(last_bit), int'(want.last));
    endtask
  endclass

endpackage

FILE: verif/overlap_cost_graph_engine_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of overlap_cost_graph_engine: loads words, queries rows
// depends on ocg_pkg, ocg_sb_pkg and the block's rtl
module overlap_cost_graph_engine_tb;
  import ocg_pkg::*;
  import ocg_sb_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 6;
  // long enough for a full query walk, leaving margin before register writes
  localparam int DRAIN_CYCLES   = OCG_MAX_VERTICES + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 32;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_op = OP_LOAD;
  logic [VIDX_W-1:0]     in_vertex_index = '0;
  logic [WORD_IN_W-1:0]  in_word_symbols = '0;
  logic                  out_valid;
  logic [VIDX_W-1:0]     out_column;
  logic [COST_W-1:0]     out_edge_cost;
  logic                  out_is_edge;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_WORD_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cost_row_scoreboard sb;
  bit burst_mode = 1'b0;   // phase with no idle gaps on the input side
  int settings = 0;
  int idle_cycles = 0;

  overlap_cost_graph_engine u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_vertex_index (in_vertex_index),
    .in_word_symbols (in_word_symbols),
    .out_valid       (out_valid),
    .out_column      (out_column),
    .out_edge_cost   (out_edge_cost),
    .out_is_edge     (out_is_edge),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // result monitor and watchdog; outputs are read at the edge, before any update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_column, out_edge_cost, out_is_edge, out_last);
      if ((start && !busy) || out_valid || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles", idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // random words that overlap often: continue another word's suffix, or use two symbols only;
  // the rest are fully random so every bit of the field toggles
  function automatic logic [WORD_IN_W-1:0] make_word(int len);
    logic [WORD_IN_W-1:0] w;
    logic [WORD_IN_W-1:0] src;
    int k;
    int style;
    w = {$urandom, $urandom};
    style = $urandom_range(0, 9);
    if (style < 4) begin
      src = sb.words[$urandom_range(0, OCG_MAX_VERTICES - 1)];
      k = $urandom_range(1, len - 1);
      for (int j = 0; j < k; j++)
        w[j * OCG_SYMBOL_BITS +: OCG_SYMBOL_BITS] =
          src[(len - k + j) * OCG_SYMBOL_BITS +: OCG_SYMBOL_BITS];
    end else if (style < 7) begin
      for (int j = 0; j < OCG_MAX_SYMBOLS; j++)
        w[j * OCG_SYMBOL_BITS +: OCG_SYMBOL_BITS] = w[j * OCG_SYMBOL_BITS] ? 4'hA : 4'h5;
    end
    return w;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  task automatic idle_after_item();
    int gap;
    int roll;
    gap = 0;
    if (!burst_mode) begin
      roll = $urandom_range(0, 99);
      if (roll >= 90) gap = $urandom_range(10, 40);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // start stays high until an edge sees busy low; that edge accepts the item
  task automatic drive_item(logic op, logic [VIDX_W-1:0] idx, logic [WORD_IN_W-1:0] word);
    start           <= 1'b1;
    in_op           <= op;
    in_vertex_index <= idx;
    in_word_symbols <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(op, idx, word);
    idle_after_item();
  endtask

  task automatic random_item();
    if ($urandom_range(0, 99) < 45)
      drive_item(OP_QUERY, VIDX_W'($urandom_range(0, OCG_MAX_VERTICES - 1)), {$urandom, $urandom});
    else
      drive_item(OP_LOAD, VIDX_W'($urandom_range(0, OCG_MAX_VERTICES - 1)),
                 make_word(sb.eff_len()));
  endtask

  // wait for every expected entry, then for a full walk so an empty query is done too
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both registers, one write per cycle, only while the block is idle
  task automatic apply_setting(logic [CFG_DATA_W-1:0] len_data,
                               logic [CFG_DATA_W-1:0] cnt_data);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WORD_LENGTH;
    cfg_data  <= len_data;
    @(posedge clk);
    sb.write_reg(CFG_WORD_LENGTH, len_data);
    cfg_index <= CFG_VERTEX_COUNT;
    cfg_data  <= cnt_data;
    @(posedge clk);
    sb.write_reg(CFG_VERTEX_COUNT, cnt_data);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every slot first so no query ever reads an unwritten word
    for (int s = 0; s < OCG_MAX_VERTICES; s++)
      drive_item(OP_LOAD, VIDX_W'(s), make_word(sb.eff_len()));

    // directed rows at reset length 10
    // all-ones and all-zero words overlap fully: overlap L-1 gives the smallest cost
    drive_item(OP_LOAD, 6'd2, '1);
    drive_item(OP_LOAD, 6'd3, '1);
    drive_item(OP_LOAD, 6'd4, '0);
    drive_item(OP_LOAD, 6'd62, '0);
    drive_item(OP_QUERY, 6'd2, '0);
    drive_item(OP_QUERY, 6'd4, '1);
    // rows whose diagonal falls on the fixed zero columns, and the highest vertex
    drive_item(OP_QUERY, 6'd0, '0);
    drive_item(OP_QUERY, 6'd1, '0);
    drive_item(OP_QUERY, 6'd63, '1);
    // distinct symbols; slot 11 differs only above the word length
    drive_item(OP_LOAD, 6'd10, 64'h0000_0098_7654_3210);
    drive_item(OP_LOAD, 6'd11, 64'hFFFF_FF98_7654_3210);
    // overlaps of one, two and three symbols with rows 10 and 11
    drive_item(OP_LOAD, 6'd12, 64'h5555_5555_5555_5559);
    drive_item(OP_LOAD, 6'd13, 64'h5555_5555_5555_5598);
    drive_item(OP_LOAD, 6'd14, 64'h5555_5555_5555_5987);
    drive_item(OP_QUERY, 6'd10, '0);
    drive_item(OP_QUERY, 6'd11, '1);
    drain();

    // register settings: both extremes, saturation above and below range,
    // an empty row, tiny rows where most queried vertices are unused, then random ones
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       apply_setting(7'd16, 7'd64);
        1:       apply_setting(7'd2, 7'd3);
        2:       apply_setting(7'd31, 7'd127);
        3:       apply_setting(7'd0, 7'd64);
        4:       apply_setting(7'd1, 7'd0);
        5:       apply_setting(7'd7, 7'd1);
        6:       apply_setting(7'd4, 7'd2);
        7:       apply_setting(7'd17, 7'd65);
        8:       apply_setting(7'd12, 7'd40);
        9:       apply_setting(7'd3, 7'd64);
        default: apply_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      endcase
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
      drain();
    end

    if (sb.pending() != 0) sb.report("entries never seen, count", sb.pending(), 0);
    $display("covered %0d loads and %0d queries, %0d row entries checked",
             sb.loads, sb.queries, sb.checked);
    $display("over %0d register settings incl. saturated length and count", settings);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
